// ===== rtl/imu_fp_pkg.sv =====
// ----------------------------------------------------------------------------
// imu_fp_pkg
// Shared types and constants of the sensor frame parser: frame layout, type
// codes, axis scale factors and the record passed from front to back.
// ----------------------------------------------------------------------------
package imu_fp_pkg;

  localparam int FRAME_LEN    = 11;
  localparam int WINDOW_DEPTH = FRAME_LEN - 1;
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int BYTE_W       = 8;
  localparam int WORD_W       = 16;
  localparam int AXIS_W       = 25;
  localparam int SCALE_W      = 10;
  localparam int PROD_W       = WORD_W + SCALE_W;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] HEADER_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_ACCEL  = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_RATE   = 8'h52;
  localparam logic [BYTE_W-1:0] TYPE_ANGLE  = 8'h53;

  // q.13 factors: 16/32768, 2000/32768 and 180/32768 times 8192
  localparam logic signed [SCALE_W-1:0] SCALE_ACCEL = 10'sd4;
  localparam logic signed [SCALE_W-1:0] SCALE_RATE  = 10'sd500;
  localparam logic signed [SCALE_W-1:0] SCALE_ANGLE = 10'sd45;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_RATE  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                    kind;
    logic signed [WORD_W-1:0] d0;
    logic signed [WORD_W-1:0] d1;
    logic signed [WORD_W-1:0] d2;
    logic signed [WORD_W-1:0] d3;
  } frame_t;

endpackage

// ===== rtl/imu_fp_if.sv =====
// ----------------------------------------------------------------------------
// imu_fp_in_if / imu_fp_out_if
// Valid/ready channels of the parser: received bytes in, decoded frames out.
// ----------------------------------------------------------------------------
interface imu_fp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_burst;

  modport source (output valid, output rx_byte, output end_of_burst, input ready);
  modport sink   (input valid, input rx_byte, input end_of_burst, output ready);
endinterface

interface imu_fp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         frame_kind;
  logic signed [24:0] axis_x;
  logic signed [24:0] axis_y;
  logic signed [24:0] axis_z;
  logic signed [15:0] temperature_centi;
  logic               sample_complete;

  modport source (output valid, output frame_kind, output axis_x, output axis_y,
                  output axis_z, output temperature_centi, output sample_complete,
                  input ready);
  modport sink   (input valid, input frame_kind, input axis_x, input axis_y,
                  input axis_z, input temperature_centi, input sample_complete,
                  output ready);
endinterface

// ===== rtl/imu_fp_front.sv =====
// ----------------------------------------------------------------------------
// imu_fp_front
// Byte window, header and checksum check, frame classification. Pushes one
// record per decodable frame into the queue.
// ----------------------------------------------------------------------------
module imu_fp_front (
  input  logic               clk,
  input  logic               rst_n,
  imu_fp_in_if.sink          in_ch,
  input  logic               q_full,
  output logic               push_valid,
  output imu_fp_pkg::frame_t push_data
);
  import imu_fp_pkg::*;

  logic [BYTE_W-1:0] win_r [WINDOW_DEPTH];
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              accept;
  logic              full_now;
  logic [BYTE_W-1:0] sum;
  logic              frame_ok;
  logic              known;
  kind_t             kind;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign full_now    = (cnt_r == CNT_W'(WINDOW_DEPTH));

  always_comb begin
    sum = '0;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      sum = sum + win_r[i];
    end
  end

  assign frame_ok = full_now && (win_r[0] == HEADER_BYTE) && (sum == in_ch.rx_byte);

  always_comb begin
    known = 1'b1;
    kind  = KIND_ACCEL;
    priority if (win_r[1] == TYPE_ACCEL) begin
      kind = KIND_ACCEL;
    end else if (win_r[1] == TYPE_RATE) begin
      kind = KIND_RATE;
    end else if (win_r[1] == TYPE_ANGLE) begin
      kind = KIND_ANGLE;
    end else begin
      known = 1'b0;
    end
  end

  assign push_valid     = accept && frame_ok && known;
  assign push_data.kind = kind;
  assign push_data.d0   = {win_r[3], win_r[2]};
  assign push_data.d1   = {win_r[5], win_r[4]};
  assign push_data.d2   = {win_r[7], win_r[6]};
  assign push_data.d3   = (kind == KIND_ACCEL) ? {win_r[9], win_r[8]} : '0;

  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      if (!full_now) begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end else if (frame_ok) begin
        cnt_nxt = '0;
      end else begin
        cnt_nxt = CNT_W'(WINDOW_DEPTH);
      end
      if (in_ch.end_of_burst) begin
        cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // window storage, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!full_now) begin
        win_r[cnt_r] <= in_ch.rx_byte;
      end else if (!frame_ok) begin
        for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[WINDOW_DEPTH-1] <= in_ch.rx_byte;
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window count out of range");

  a_burst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.end_of_burst |=> cnt_r == '0)
    else $error("window not cleared at end of burst");

  a_bad_drop: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full_now && !frame_ok && !in_ch.end_of_burst |=> full_now)
    else $error("rejected frame did not keep ten bytes");

  a_push_header: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> win_r[0] == HEADER_BYTE && !q_full)
    else $error("push without header or into full queue");

endmodule

// ===== rtl/imu_fp_queue.sv =====
// ----------------------------------------------------------------------------
// imu_fp_queue
// Small fifo of classified frames between the front and the back.
// ----------------------------------------------------------------------------
module imu_fp_queue #(
  parameter int unsigned DEPTH = imu_fp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  input  imu_fp_pkg::frame_t push_data,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop_ready,
  output imu_fp_pkg::frame_t pop_data
);
  import imu_fp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int QCNT_W = $clog2(DEPTH + 1);

  frame_t              mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = (count_r == QCNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    unique case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + QCNT_W'(1);
      2'b01:   count_nxt = count_r - QCNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(DEPTH))
    else $error("queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push_valid && full))
    else $error("push into full queue");

  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    do_push && !do_pop |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue count did not follow push");

endmodule

// ===== rtl/imu_fp_back.sv =====
// ----------------------------------------------------------------------------
// imu_fp_back
// Scales the three axis words to q.13 and holds the result in the output
// register until it is taken.
// ----------------------------------------------------------------------------
module imu_fp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  imu_fp_pkg::frame_t pop_data,
  imu_fp_out_if.source       out_ch
);
  import imu_fp_pkg::*;

  logic                      out_valid_r;
  kind_t                     kind_r;
  logic signed [AXIS_W-1:0]  x_r, y_r, z_r;
  logic signed [WORD_W-1:0]  temp_r;
  logic                      done_r;
  logic                      load;
  logic signed [SCALE_W-1:0] scale;
  logic signed [PROD_W-1:0]  px, py, pz;

  assign pop_ready = !out_valid_r || out_ch.ready;
  assign load      = pop_valid && pop_ready;

  always_comb begin
    unique case (pop_data.kind)
      KIND_ACCEL: scale = SCALE_ACCEL;
      KIND_RATE:  scale = SCALE_RATE;
      KIND_ANGLE: scale = SCALE_ANGLE;
      default:    scale = '0;
    endcase
  end

  assign px = pop_data.d0 * scale;
  assign py = pop_data.d1 * scale;
  assign pz = pop_data.d2 * scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop_ready) begin
      out_valid_r <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= pop_data.kind;
      x_r    <= px[AXIS_W-1:0];
      y_r    <= py[AXIS_W-1:0];
      z_r    <= pz[AXIS_W-1:0];
      temp_r <= pop_data.d3;
      done_r <= (pop_data.kind == KIND_ANGLE);
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.frame_kind        = kind_r;
  assign out_ch.axis_x            = x_r;
  assign out_ch.axis_y            = y_r;
  assign out_ch.axis_z            = z_r;
  assign out_ch.temperature_centi = temp_r;
  assign out_ch.sample_complete   = done_r;

  a_done_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> done_r == (kind_r == KIND_ANGLE))
    else $error("sample complete flag disagrees with kind");

  a_temp_accel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r != KIND_ACCEL |-> temp_r == '0)
    else $error("temperature on non acceleration word");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("loaded word not presented");

endmodule

// ===== rtl/imu_frame_parser.sv =====
// the ten-byte sum and header check are combinational; the queue feeds the output register
// throughput: one byte per cycle while the frame queue is not full
// the result register and the frame queue let bytes flow while a result waits
// reset clears the window count, queue pointers and output valid; window bytes are not cleared
// ----------------------------------------------------------------------------
// imu_frame_parser
// Finds 11-byte sensor frames in a byte stream, checks header and checksum
// and emits acceleration, angular rate and angle words in q.13.
// ----------------------------------------------------------------------------
module imu_frame_parser #(
  parameter int unsigned QUEUE_DEPTH = imu_fp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  imu_fp_in_if.sink     in_ch,
  imu_fp_out_if.source  out_ch
);
  import imu_fp_pkg::*;

  logic   push_valid;
  frame_t push_data;
  logic   q_full;
  logic   pop_valid;
  logic   pop_ready;
  frame_t pop_data;

  imu_fp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  imu_fp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (q_full),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  imu_fp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== dv/tb_imu_frame_parser.sv =====
// ----------------------------------------------------------------------------
// tb_imu_frame_parser
// Byte stream checker for the sensor frame parser. A queue of bytes (directed
// frames, broken frames, noise, burst ends, then mostly random well-formed
// frames) feeds a driver with random gaps. Every accepted byte runs through a
// local frame decoder that queues the expected result words; a monitor with
// random stalls and one long hold-off compares each result word field by field.
// ----------------------------------------------------------------------------
module tb_imu_frame_parser;
  import imu_fp_pkg::*;

  typedef struct {
    logic [7:0] rx_byte;
    logic       eob;
  } rx_item_t;

  typedef struct {
    kind_t              kind;
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic signed [24:0] z;
    logic signed [15:0] temp;
    logic               done;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_off = 1'b0;

  imu_fp_in_if  in_if ();
  imu_fp_out_if out_if ();

  imu_frame_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  rx_item_t      byte_q[$];
  frame_result_t decoded_q[$];

  logic [7:0]  win [0:FRAME_LEN-1];
  int unsigned win_cnt = 0;

  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned send_gap = 0;
  int unsigned in_calm = 0;
  int unsigned stall = 0;
  int unsigned out_calm = 0;
  int unsigned good_frames = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // frame decoder, one received byte at a time
  task automatic parse_byte(input logic [7:0] b, input logic eob);
    logic [7:0]         sum;
    logic signed [15:0] w [0:3];
    int                 scale;
    frame_result_t      res;
    if (win_cnt >= FRAME_LEN) win_cnt = 0;
    win[win_cnt] = b;
    win_cnt++;
    if (win_cnt == FRAME_LEN) begin
      sum = 8'd0;
      for (int k = 0; k < FRAME_LEN - 1; k++) sum = sum + win[k];
      if (win[0] == HEADER_BYTE && sum == win[FRAME_LEN-1]) begin
        for (int k = 0; k < 4; k++) w[k] = {win[2*k+3], win[2*k+2]};
        scale = 0;
        res.temp = '0;
        res.done = 1'b0;
        if (win[1] == TYPE_ACCEL) begin
          res.kind = KIND_ACCEL;
          scale = int'(SCALE_ACCEL);
          res.temp = w[3];
        end else if (win[1] == TYPE_RATE) begin
          res.kind = KIND_RATE;
          scale = int'(SCALE_RATE);
        end else if (win[1] == TYPE_ANGLE) begin
          res.kind = KIND_ANGLE;
          scale = int'(SCALE_ANGLE);
          res.done = 1'b1;
        end
        if (scale != 0) begin
          res.x = 25'(int'(w[0]) * scale);
          res.y = 25'(int'(w[1]) * scale);
          res.z = 25'(int'(w[2]) * scale);
          decoded_q.push_back(res);
        end
        win_cnt = 0;
      end else begin
        for (int k = 0; k < FRAME_LEN - 1; k++) win[k] = win[k+1];
        win_cnt = FRAME_LEN - 1;
      end
    end
    if (eob) win_cnt = 0;
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_result();
    frame_result_t want;
    if (decoded_q.size() == 0) begin
      report_mismatch("unexpected result word, kind", out_if.frame_kind, 0);
      return;
    end
    want = decoded_q.pop_front();
    if (out_if.frame_kind !== want.kind)
      report_mismatch("frame_kind", out_if.frame_kind, want.kind);
    if (out_if.axis_x !== want.x) report_mismatch("axis_x", out_if.axis_x, want.x);
    if (out_if.axis_y !== want.y) report_mismatch("axis_y", out_if.axis_y, want.y);
    if (out_if.axis_z !== want.z) report_mismatch("axis_z", out_if.axis_z, want.z);
    if (out_if.temperature_centi !== want.temp)
      report_mismatch("temperature_centi", out_if.temperature_centi, want.temp);
    if (out_if.sample_complete !== want.done)
      report_mismatch("sample_complete", out_if.sample_complete, want.done);
  endtask

  // mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'h0000;
    if (r == 3) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic add_byte(input logic [7:0] b, input logic eob);
    rx_item_t it;
    it.rx_byte = b;
    it.eob = eob;
    byte_q.push_back(it);
  endtask

  task automatic add_frame(input logic [7:0] hdr, input logic [7:0] typ,
                           input logic [15:0] d0, input logic [15:0] d1,
                           input logic [15:0] d2, input logic [15:0] d3,
                           input logic [7:0] csum_flip, input bit last);
    logic [7:0] fb [0:FRAME_LEN-1];
    logic [7:0] sum;
    fb[0] = hdr;
    fb[1] = typ;
    {fb[3], fb[2]} = d0;
    {fb[5], fb[4]} = d1;
    {fb[7], fb[6]} = d2;
    {fb[9], fb[8]} = d3;
    sum = 8'd0;
    for (int k = 0; k < FRAME_LEN - 1; k++) sum = sum + fb[k];
    fb[FRAME_LEN-1] = sum ^ csum_flip;
    for (int k = 0; k < FRAME_LEN; k++) add_byte(fb[k], last && (k == FRAME_LEN - 1));
  endtask

  task automatic add_noise(input int unsigned n, input bit last);
    for (int unsigned k = 0; k < n; k++) add_byte(8'($urandom), last && (k == n - 1));
  endtask

  // byte driver
  always @(posedge clk) begin
    rx_item_t cur;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        parse_byte(in_if.rx_byte, in_if.end_of_burst);
        bytes_taken++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          in_if.valid <= 1'b0;
          send_gap--;
        end else if (byte_q.size() > 0) begin
          cur = byte_q.pop_front();
          in_if.rx_byte <= cur.rx_byte;
          in_if.end_of_burst <= cur.eob;
          in_if.valid <= 1'b1;
          if (in_calm > 0) begin
            in_calm--;
            send_gap = 0;
          end else begin
            send_gap = gap_len();
            if ($urandom_range(0, 39) == 0) in_calm = $urandom_range(30, 80);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and ready pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) check_result();
      if (stall > 0) begin
        stall--;
      end else if (out_calm > 0) begin
        out_calm--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall = gap_len();
      end else if ($urandom_range(0, 49) == 0) begin
        out_calm = $urandom_range(30, 100);
      end
      out_if.ready <= !hold_off && (stall == 0);
    end
  end

  // long receiver hold-off while frames keep streaming in
  initial begin
    wait (rst_n === 1'b1);
    while (bytes_taken < 250) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #4000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned r;
    logic [7:0]  typ;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'd0;
    in_if.end_of_burst = 1'b0;
    out_if.ready = 1'b0;

    // field extremes for every frame type
    add_frame(HEADER_BYTE, TYPE_ACCEL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 8'h00, 1'b0);
    add_frame(HEADER_BYTE, TYPE_ACCEL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 8'h00, 1'b0);
    add_frame(HEADER_BYTE, TYPE_RATE, 16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 8'h00, 1'b0);
    add_frame(HEADER_BYTE, TYPE_ANGLE, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h1234, 8'h00, 1'b0);
    // valid frame of an unknown type, no result
    add_frame(HEADER_BYTE, 8'h54, 16'h1111, 16'h2222, 16'h3333, 16'h4444, 8'h00, 1'b0);
    // bad header, then burst end clears the leftover
    add_frame(8'h54, TYPE_ACCEL, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 8'h00, 1'b1);
    // bad checksum, then resync onto the next frame
    add_frame(HEADER_BYTE, TYPE_RATE, 16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0, 8'h01, 1'b0);
    add_frame(HEADER_BYTE, TYPE_ANGLE, 16'h0001, 16'hFFFE, 16'h4000, 16'hC000, 8'h00, 1'b0);
    // noise ahead of a frame that ends on the last byte of a burst
    add_noise(3, 1'b0);
    add_frame(HEADER_BYTE, TYPE_ACCEL, 16'hFFFF, 16'h0001, 16'h8001, 16'hFC18, 8'h00, 1'b1);
    // partial frame cut by burst end
    add_byte(HEADER_BYTE, 1'b0);
    add_byte(TYPE_RATE, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h7F, 1'b1);
    add_frame(HEADER_BYTE, TYPE_RATE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 8'h00, 1'b0);

    while (byte_q.size() < 650 || good_frames < 30) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        case ($urandom_range(0, 2))
          0: typ = TYPE_ACCEL;
          1: typ = TYPE_RATE;
          default: typ = TYPE_ANGLE;
        endcase
        add_frame(HEADER_BYTE, typ, rand_word(), rand_word(), rand_word(), rand_word(),
                  8'h00, $urandom_range(0, 4) == 0);
        good_frames++;
      end else if (r < 74) begin
        add_frame(HEADER_BYTE, 8'($urandom), rand_word(), rand_word(), rand_word(),
                  rand_word(), 8'h00, $urandom_range(0, 1));
      end else if (r < 82) begin
        add_frame(HEADER_BYTE, TYPE_ACCEL + 8'($urandom_range(0, 2)), rand_word(),
                  rand_word(), rand_word(), rand_word(), 8'($urandom_range(1, 255)),
                  $urandom_range(0, 1));
      end else if (r < 86) begin
        add_frame(8'($urandom), TYPE_ANGLE, rand_word(), rand_word(), rand_word(),
                  rand_word(), 8'h00, $urandom_range(0, 1));
      end else if (r < 95) begin
        add_noise($urandom_range(1, 8), $urandom_range(0, 3) == 0);
      end else begin
        add_byte(HEADER_BYTE, 1'b0);
        add_noise($urandom_range(1, 9), 1'b1);
      end
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (byte_q.size() > 0 || in_if.valid !== 1'b0);
    while (decoded_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0 && decoded_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
